// ===== src/gft_pkg.sv =====
// ----------------------------------------------------------------------------
// gft_pkg
// Shared types and codes for the grammar text tokenizer.
// ----------------------------------------------------------------------------
package gft_pkg;

    // token kinds
    localparam logic [2:0] KIND_START = 3'd0;
    localparam logic [2:0] KIND_TOKEN = 3'd1;
    localparam logic [2:0] KIND_ARROW = 3'd2;
    localparam logic [2:0] KIND_PIPE  = 3'd3;
    localparam logic [2:0] KIND_IDENT = 3'd4;
    localparam logic [2:0] KIND_END   = 3'd5;
    localparam logic [2:0] KIND_BLANK = 3'd6;
    localparam logic [2:0] KIND_ERROR = 3'd7;

    // error causes
    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_BAD_CHAR  = 3'd1;
    localparam logic [2:0] CAUSE_DASH      = 3'd2;
    localparam logic [2:0] CAUSE_DIRECTIVE = 3'd3;
    localparam logic [2:0] CAUSE_TOO_LONG  = 3'd4;

    // result queue depth; two free slots needed per byte
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  cause;
        logic [31:0] start;
        logic [5:0]  len;
        logic [15:0] line;
    } t_result;

    // up to two results per byte, packed so that v1 implies v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

// ===== src/grammar_file_tokenizer.sv =====
// ----------------------------------------------------------------------------
// grammar_file_tokenizer
// Byte-stream tokenizer for grammar text: pipes, arrows, directives,
// identifiers, blank lines, end markers and errors.
// ----------------------------------------------------------------------------
// Use:
//   Slave side takes one beat per text byte: tdata[7:0] is the byte, tuser
//   high marks end of text (tdata ignored, no byte counted). Each end beat
//   yields an end token, after closing any token still open.
//   Master side gives one token per beat; tuser is the token kind, tdata
//   carries cause, start offset, length and line.
//   A byte taken into the input register is lexed from there into the
//   result queue once two slots are free; its tokens show on the master
//   side from the queue head.
//   Throughput: one byte per cycle. The lexer step is a single pass from
//   the input register to a four-entry result queue; a byte may give two
//   tokens, and the input register only advances while two queue slots
//   are free, so bursts of two-token bytes run at the master's pace.
//   Reset (synchronous, i_rst_n low): lexer idle, line 1, offset 0, queue
//   and input register empty.
//   Receiver stall: tokens wait in the queue; once fewer than two slots are
//   free the input register holds and s_axis_tready drops, nothing is lost.
// ----------------------------------------------------------------------------
module grammar_file_tokenizer #(
    parameter int MAX_IDENT_LEN         = 50,
    parameter int MAX_DIRECTIVE_LETTERS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] ch
    input  logic        s_axis_tuser,  // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [2:0] error_cause, [34:3] start_offset,
                                       // [40:35] length, [56:41] line, rest 0
    output logic [2:0]  m_axis_tuser   // [2:0] kind
);
    import gft_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_ch;
    logic       r_in_eoi;
    logic       room;
    logic       adv;
    t_push      push;
    t_result    res;

    // lex the held byte only when the queue can take both its tokens
    assign adv           = r_in_vld && room;
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_ch  <= s_axis_tdata;
            r_in_eoi <= s_axis_tuser;
        end
    end

    gft_lexer #(
        .MAX_IDENT_LEN         (MAX_IDENT_LEN),
        .MAX_DIRECTIVE_LETTERS (MAX_DIRECTIVE_LETTERS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_ch    (r_in_ch),
        .i_eoi   (r_in_eoi),
        .o_push  (push)
    );

    gft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {7'd0, res.line, res.len, res.start, res.cause};
    assign m_axis_tuser = res.kind;

endmodule

// ===== src/gft_lexer.sv =====
// ----------------------------------------------------------------------------
// gft_lexer
// Lexer state and the single-byte step; emits up to two results per byte.
// ----------------------------------------------------------------------------
module gft_lexer #(
    parameter int MAX_IDENT_LEN         = 50,
    parameter int MAX_DIRECTIVE_LETTERS = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_ch,
    input  logic           i_eoi,
    output gft_pkg::t_push o_push
);
    import gft_pkg::*;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_NEWLINE = 3'd1;
    localparam logic [2:0] M_DASH    = 3'd2;
    localparam logic [2:0] M_PERCENT = 3'd3;
    localparam logic [2:0] M_IDENT   = 3'd4;

    localparam logic [5:0] IDENT_MAX = 6'(MAX_IDENT_LEN);
    localparam logic [5:0] DIR_MAX   = 6'(MAX_DIRECTIVE_LETTERS);

    logic [2:0]  r_mode, n_mode;
    logic [5:0]  r_cnt, n_cnt;
    logic [1:0]  r_dm, n_dm;
    logic [15:0] r_line, n_line;
    logic [31:0] r_off, n_off;
    logic [31:0] r_tstart, n_tstart;

    logic [15:0] line_inc;
    logic        a_v, b_v, do_fresh;
    t_result     a_res, b_res;

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        is_ident = is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == 8'h5f;
    endfunction

    function automatic logic [7:0] start_letter(input logic [2:0] i);
        case (i)
            3'd0:    start_letter = 8'h73; // s
            3'd1:    start_letter = 8'h74; // t
            3'd2:    start_letter = 8'h61; // a
            3'd3:    start_letter = 8'h72; // r
            3'd4:    start_letter = 8'h74; // t
            default: start_letter = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] token_letter(input logic [2:0] i);
        case (i)
            3'd0:    token_letter = 8'h74; // t
            3'd1:    token_letter = 8'h6f; // o
            3'd2:    token_letter = 8'h6b; // k
            3'd3:    token_letter = 8'h65; // e
            3'd4:    token_letter = 8'h6e; // n
            default: token_letter = 8'h00;
        endcase
    endfunction

    function automatic t_result mk(input logic [2:0] k, input logic [2:0] c,
                                   input logic [31:0] s, input logic [5:0] l,
                                   input logic [15:0] ln);
        t_result r;
        r.kind  = k;
        r.cause = c;
        r.start = s;
        r.len   = l;
        r.line  = ln;
        mk = r;
    endfunction

    assign line_inc = (r_line == 16'hffff) ? r_line : r_line + 16'd1;

    always_comb begin
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_dm     = r_dm;
        n_line   = r_line;
        n_tstart = r_tstart;
        n_off    = i_eoi ? r_off : r_off + 32'd1;
        a_v      = 1'b0;
        a_res    = mk(KIND_END, CAUSE_NONE, r_off, 6'd0, r_line);
        b_v      = 1'b0;
        b_res    = mk(KIND_END, CAUSE_NONE, r_off, 6'd0, r_line);
        do_fresh = 1'b0;

        // token in progress
        case (r_mode)
            M_NEWLINE: begin
                if (!i_eoi && i_ch == 8'h0a) begin
                    n_line = line_inc;
                    n_mode = M_IDLE;
                    a_v    = 1'b1;
                    a_res  = mk(KIND_BLANK, CAUSE_NONE, r_tstart, 6'd2, line_inc);
                end else begin
                    do_fresh = 1'b1;
                end
            end
            M_DASH: begin
                a_v = 1'b1;
                if (i_eoi) begin
                    a_res    = mk(KIND_ERROR, CAUSE_DASH, r_tstart, 6'd1, r_line);
                    do_fresh = 1'b1;
                end else begin
                    n_mode = M_IDLE;
                    if (i_ch == 8'h3e) begin
                        a_res = mk(KIND_ARROW, CAUSE_NONE, r_tstart, 6'd2, r_line);
                    end else begin
                        a_res = mk(KIND_ERROR, CAUSE_DASH, r_tstart, 6'd2, r_line);
                    end
                end
            end
            M_PERCENT: begin
                if (!i_eoi && is_alpha(i_ch) && r_cnt < DIR_MAX) begin
                    if (r_cnt < 6'd5) begin
                        if (i_ch != start_letter(r_cnt[2:0])) n_dm[0] = 1'b0;
                        if (i_ch != token_letter(r_cnt[2:0])) n_dm[1] = 1'b0;
                    end else begin
                        n_dm = 2'b00;
                    end
                    n_cnt = r_cnt + 6'd1;
                end else begin
                    a_v = 1'b1;
                    if (r_cnt == 6'd5 && r_dm[0]) begin
                        a_res = mk(KIND_START, CAUSE_NONE, r_tstart, 6'd6, r_line);
                    end else if (r_cnt == 6'd5 && r_dm[1]) begin
                        a_res = mk(KIND_TOKEN, CAUSE_NONE, r_tstart, 6'd6, r_line);
                    end else begin
                        a_res = mk(KIND_ERROR, CAUSE_DIRECTIVE, r_tstart,
                                   r_cnt + 6'd1, r_line);
                    end
                    do_fresh = 1'b1;
                end
            end
            M_IDENT: begin
                if (!i_eoi && is_ident(i_ch)) begin
                    if (r_cnt < IDENT_MAX) begin
                        n_cnt = r_cnt + 6'd1;
                    end else begin
                        n_mode = M_IDLE;
                        a_v    = 1'b1;
                        a_res  = mk(KIND_ERROR, CAUSE_TOO_LONG, r_tstart, IDENT_MAX,
                                    r_line);
                    end
                end else begin
                    a_v      = 1'b1;
                    a_res    = mk(KIND_IDENT, CAUSE_NONE, r_tstart, r_cnt, r_line);
                    do_fresh = 1'b1;
                end
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase

        // byte taken as the start of a new token
        if (do_fresh) begin
            n_mode = M_IDLE;
            if (i_eoi) begin
                b_v   = 1'b1;
                b_res = mk(KIND_END, CAUSE_NONE, r_off, 6'd0, r_line);
            end else if (i_ch != 8'h20 && i_ch != 8'h09) begin
                n_tstart = r_off;
                if (i_ch == 8'h0a) begin
                    n_line = line_inc;
                    n_mode = M_NEWLINE;
                end else if (i_ch == 8'h7c) begin
                    b_v   = 1'b1;
                    b_res = mk(KIND_PIPE, CAUSE_NONE, r_off, 6'd1, r_line);
                end else if (i_ch == 8'h2d) begin
                    n_mode = M_DASH;
                end else if (i_ch == 8'h25) begin
                    n_cnt  = 6'd0;
                    n_dm   = 2'b11;
                    n_mode = M_PERCENT;
                end else if (is_alpha(i_ch) || i_ch == 8'h5f) begin
                    n_cnt  = 6'd1;
                    n_mode = M_IDENT;
                end else begin
                    b_v   = 1'b1;
                    b_res = mk(KIND_ERROR, CAUSE_BAD_CHAR, r_off, 6'd1, r_line);
                end
            end
        end
    end

    // compact: first slot always used first
    always_comb begin
        o_push.v0   = i_step && (a_v || b_v);
        o_push.v1   = i_step && a_v && b_v;
        o_push.res0 = a_v ? a_res : b_res;
        o_push.res1 = b_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_cnt    <= 6'd0;
            r_dm     <= 2'b11;
            r_line   <= 16'd1;
            r_off    <= 32'd0;
            r_tstart <= 32'd0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
            r_dm     <= n_dm;
            r_line   <= n_line;
            r_off    <= n_off;
            r_tstart <= n_tstart;
        end
    end

endmodule

// ===== src/gft_queue.sv =====
// ----------------------------------------------------------------------------
// gft_queue
// Shift-register result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module gft_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gft_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output gft_pkg::t_result o_res
);
    import gft_pkg::*;

    localparam logic [QCNT_W-1:0] DEPTH_C = QCNT_W'(QUEUE_DEPTH);

    t_result           r_q [QUEUE_DEPTH];
    t_result           n_q [QUEUE_DEPTH];
    logic [QCNT_W-1:0] r_cnt, n_cnt, base;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_q[0];
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_cnt <= DEPTH_C - QCNT_W'(2));
    assign base    = r_cnt - QCNT_W'(pop);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && i < QUEUE_DEPTH - 1) n_q[i] = r_q[(i + 1) % QUEUE_DEPTH];
            else                           n_q[i] = r_q[i];
            if (i_push.v0 && QCNT_W'(i) == base) n_q[i] = i_push.res0;
            if (i_push.v1 && QCNT_W'(i) == base + QCNT_W'(1)) n_q[i] = i_push.res1;
        end
        n_cnt = base + QCNT_W'(i_push.v0) + QCNT_W'(i_push.v1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C)
        else $error("result queue count beyond depth");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0)
        else $error("second result pushed without first");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> o_room)
        else $error("push into full result queue");

    a_pop_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.v0) |=> (r_cnt == $past(r_cnt) - QCNT_W'(1)))
        else $error("pop did not drain one entry");

endmodule
